[rtl/core/ogre_pkg.sv]
package ogre_pkg;

	localparam int MAX_COLS_DEF  = 64;
	localparam int MAX_ROWS_DEF  = 64;
	localparam int COST_BITS_DEF = 16;

	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CRD_W     = 10;

	localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_PAINT     = 3'd0,
		OP_CELL_BLK  = 3'd1,
		OP_RECT_BLK  = 3'd2,
		OP_CELL_COST = 3'd3,
		OP_RECT_COST = 3'd4,
		OP_ADD_COST  = 3'd5,
		OP_CLEAR     = 3'd6
	} op_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic rd;
		logic use_data;
		logic paint;
		logic clr;
		logic emit;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic skip;
		logic last;
		logic clr_last;
	} status_t;

	function automatic logic signed [CRD_W-1:0] clamp(input logic signed [CRD_W-1:0] v,
		input logic signed [CRD_W-1:0] lo, input logic signed [CRD_W-1:0] hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

endpackage

[rtl/core/ogre_in_if.sv]
interface ogre_in_if;
	logic              valid;
	logic              ready;
	logic [2:0]        operation;
	logic signed [7:0] left_col;
	logic signed [7:0] top_row;
	logic signed [7:0] right_col;
	logic signed [7:0] bottom_row;
	logic              block_value;
	logic signed [7:0] cost_delta;

	modport source (output valid, operation, left_col, top_row, right_col, bottom_row,
		block_value, cost_delta, input ready);
	modport sink (input valid, operation, left_col, top_row, right_col, bottom_row,
		block_value, cost_delta, output ready);
endinterface

[rtl/core/ogre_out_if.sv]
interface ogre_out_if;
	logic               valid;
	logic               ready;
	logic               blocked;
	logic signed [31:0] cost_sum;

	modport source (output valid, blocked, cost_sum, input ready);
	modport sink (input valid, blocked, cost_sum, output ready);
endinterface

[rtl/core/ogre_ctrl.sv]
module ogre_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ogre_pkg::status_t status,
	output ogre_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_INIT, S_IDLE, S_SETUP, S_PAINT, S_RD, S_USE, S_CLEAR, S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   emit_ok;

	assign emit_ok   = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == S_IDLE) && in_valid;
		cmd.setup    = (state_q == S_SETUP);
		cmd.paint    = (state_q == S_PAINT);
		cmd.rd       = (state_q == S_RD);
		cmd.use_data = (state_q == S_USE);
		cmd.clr      = (state_q == S_INIT) || (state_q == S_CLEAR);
		cmd.emit     = (state_q == S_FIN) && emit_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					if (status.clr_last)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid)
						state_q <= S_SETUP;
				end
				S_SETUP: begin
					if (status.op == ogre_pkg::OP_CLEAR)
						state_q <= S_CLEAR;
					else if (status.skip)
						state_q <= S_FIN;
					else if (status.op == ogre_pkg::OP_PAINT)
						state_q <= S_PAINT;
					else
						state_q <= S_RD;
				end
				S_PAINT: begin
					if (status.last)
						state_q <= S_FIN;
				end
				S_RD: begin
					state_q <= S_USE;
				end
				S_USE: begin
					state_q <= status.last ? S_FIN : S_RD;
				end
				S_CLEAR: begin
					if (status.clr_last)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (emit_ok)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/ogre_dp.sv]
module ogre_dp #(
	parameter int MAX_COLS  = ogre_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS  = ogre_pkg::MAX_ROWS_DEF,
	parameter int COST_BITS = ogre_pkg::COST_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ogre_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ogre_pkg::CFG_W-1:0]     cfg_data,
	input  logic [2:0]                     operation,
	input  logic signed [7:0]              left_col,
	input  logic signed [7:0]              top_row,
	input  logic signed [7:0]              right_col,
	input  logic signed [7:0]              bottom_row,
	input  logic                           block_value,
	input  logic signed [7:0]              cost_delta,
	input  ogre_pkg::cmd_t                 cmd,
	output ogre_pkg::status_t              status,
	output logic                           blocked,
	output logic signed [31:0]             cost_sum
);

	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(MAX_COLS);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int SW    = COST_BITS + AW + 1;
	localparam int XW    = (SW > 33) ? SW : 33;
	localparam int CV    = COST_BITS + 1;
	localparam int N     = ogre_pkg::CRD_W;
	localparam logic signed [CV-1:0] CMAX = {2'b00, {(COST_BITS-1){1'b1}}};
	localparam logic signed [CV-1:0] CMIN = {2'b11, {(COST_BITS-1){1'b0}}};

	logic [ogre_pkg::CFG_W-1:0] gw_q, gh_q;
	ogre_pkg::op_t     op_q;
	logic signed [7:0] l_q, t_q, r_q, b_q, delta_q;
	logic              bv_q;

	logic signed [N-1:0] l, t, r, b, w, h, wm1, hm1, zero;
	logic signed [N-1:0] cl, cr, ct, cb;
	logic                empty, outside;

	logic [CW-1:0] col_q, cl_q, cr_q;
	logic [RW-1:0] row_q, cb_q;
	logic [AW-1:0] base_q, addr, clr_q;
	logic          outside_q, blk_acc_q;
	logic signed [SW-1:0] sum_q;

	logic                        blk_mem [CELLS];
	logic signed [COST_BITS-1:0] cost_mem [CELLS];
	logic                        blk_rd_q;
	logic signed [COST_BITS-1:0] cost_rd_q;
	logic                        blk_we, blk_wd, cost_we;
	logic signed [COST_BITS-1:0] cost_wd;
	logic signed [CV-1:0]        cost_new;
	logic signed [XW-1:0]        sum_x;
	logic signed [31:0]          sum_sat;
	logic                        is_query, is_cost, res_blk;

	// grid size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= ogre_pkg::CFG_W'(64);
			gh_q <= ogre_pkg::CFG_W'(64);
		end else if (cfg_we) begin
			unique case (ogre_pkg::reg_idx_t'(cfg_index))
				ogre_pkg::REG_GRID_WIDTH:  gw_q <= cfg_data;
				ogre_pkg::REG_GRID_HEIGHT: gh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= ogre_pkg::op_t'(operation);
			l_q     <= left_col;
			t_q     <= top_row;
			r_q     <= right_col;
			b_q     <= bottom_row;
			bv_q    <= block_value;
			delta_q <= cost_delta;
		end
	end

	// rectangle bounds per operation
	always_comb begin
		zero = '0;
		l = N'(l_q);
		t = N'(t_q);
		r = N'(r_q);
		b = N'(b_q);
		w = (gw_q == '0) ? N'(1) : (({3'b000, gw_q} > N'(MAX_COLS)) ? N'(MAX_COLS)
			: $signed({3'b000, gw_q}));
		h = (gh_q == '0) ? N'(1) : (({3'b000, gh_q} > N'(MAX_ROWS)) ? N'(MAX_ROWS)
			: $signed({3'b000, gh_q}));
		wm1 = w - N'(1);
		hm1 = h - N'(1);
		cl = l;
		cr = r;
		ct = t;
		cb = b;
		empty = 1'b0;
		outside = 1'b0;
		case (op_q)
			ogre_pkg::OP_PAINT: begin
				cl = ogre_pkg::clamp(l, zero, wm1);
				cr = ogre_pkg::clamp(r, zero, wm1);
				ct = ogre_pkg::clamp(t, zero, hm1);
				cb = ogre_pkg::clamp(b, zero, hm1);
				empty = (cl > cr) || (ct > cb);
			end
			ogre_pkg::OP_CELL_BLK, ogre_pkg::OP_CELL_COST: begin
				cr = l;
				cb = t;
				outside = (l < zero) || (t < zero) || (l >= w) || (t >= h);
			end
			ogre_pkg::OP_RECT_BLK, ogre_pkg::OP_RECT_COST: begin
				empty = (l > r) || (t > b);
				outside = !empty && ((l < zero) || (t < zero) || (r >= w) || (b >= h));
			end
			ogre_pkg::OP_ADD_COST: begin
				cl = (l < zero) ? zero : l;
				ct = (t < zero) ? zero : t;
				cr = (r > wm1) ? wm1 : r;
				cb = (b > hm1) ? hm1 : b;
				empty = (cl > cr) || (ct > cb);
			end
			default: empty = 1'b1;
		endcase
	end

	assign addr = (cmd.clr) ? clr_q : (base_q + AW'(col_q));

	assign status.op       = op_q;
	assign status.skip     = empty || outside;
	assign status.last     = (col_q == cr_q) && (row_q == cb_q);
	assign status.clr_last = (clr_q == AW'(CELLS - 1));

	// scan counters and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= status.clr_last ? '0 : clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			blk_acc_q <= 1'b0;
			sum_q     <= '0;
		end
		if (cmd.setup) begin
			col_q     <= cl[CW-1:0];
			cl_q      <= cl[CW-1:0];
			cr_q      <= cr[CW-1:0];
			row_q     <= ct[RW-1:0];
			cb_q      <= cb[RW-1:0];
			base_q    <= AW'(32'(ct[RW-1:0]) * MAX_COLS);
			outside_q <= outside;
		end
		if (cmd.use_data && op_q != ogre_pkg::OP_ADD_COST) begin
			blk_acc_q <= blk_acc_q | blk_rd_q;
			sum_q     <= sum_q + SW'(cost_rd_q);
		end
		if (cmd.paint || cmd.use_data) begin
			if (col_q == cr_q) begin
				col_q  <= cl_q;
				row_q  <= row_q + RW'(1);
				base_q <= base_q + AW'(MAX_COLS);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// cell memories
	assign cost_new = CV'(cost_rd_q) + CV'(delta_q);
	assign blk_we   = cmd.clr || cmd.paint;
	assign blk_wd   = cmd.clr ? 1'b0 : bv_q;
	assign cost_we  = cmd.clr || (cmd.use_data && op_q == ogre_pkg::OP_ADD_COST);
	assign cost_wd  = cmd.clr ? '0 : ((cost_new > CMAX) ? COST_BITS'(CMAX)
		: ((cost_new < CMIN) ? COST_BITS'(CMIN) : COST_BITS'(cost_new)));

	always_ff @(posedge clk) begin
		if (blk_we)
			blk_mem[addr] <= blk_wd;
		if (cmd.rd)
			blk_rd_q <= blk_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (cost_we)
			cost_mem[addr] <= cost_wd;
		if (cmd.rd)
			cost_rd_q <= cost_mem[addr];
	end

	// result word
	assign sum_x   = XW'(sum_q);
	assign sum_sat = (sum_x > XW'(ogre_pkg::INT_MAX)) ? ogre_pkg::INT_MAX
		: ((sum_x < XW'(ogre_pkg::INT_MIN)) ? ogre_pkg::INT_MIN : 32'(sum_x));
	assign is_query = (op_q == ogre_pkg::OP_CELL_BLK) || (op_q == ogre_pkg::OP_RECT_BLK) ||
		(op_q == ogre_pkg::OP_CELL_COST) || (op_q == ogre_pkg::OP_RECT_COST);
	assign is_cost  = (op_q == ogre_pkg::OP_CELL_COST) || (op_q == ogre_pkg::OP_RECT_COST);
	assign res_blk  = is_query && (outside_q || blk_acc_q);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			blocked  <= res_blk;
			cost_sum <= (is_cost && !res_blk) ? sum_sat : '0;
		end
	end

endmodule

[rtl/core/occupancy_grid_rect_engine.sv]
// occupancy grid with per-cell blocked bit and signed cost
// in_ch: command word (operation, rectangle corners, block value, cost delta)
// out_ch: one result word per command (blocked, cost_sum)
// cfg: plain write port, index 0 grid_width, index 1 grid_height
// each word is taken only when the engine is idle, one word at a time
// sequence: a setup step after the word is taken, then
//   paint: one cell and one write to the blocked memory each cycle
//   queries and add cost: per cell, a registered memory read then use
//   clear: all MAX_COLS*MAX_ROWS cells, one cell per cycle
//   empty or outside rectangles: no scan
// last, the result word is loaded into the output register
// reset: a clearing pass over all MAX_COLS*MAX_ROWS cells (4096 by default) zeroes
//   both memories; no word is taken until it ends, config writes work throughout
// stall: a finished result waits in the output register; the next word is
//   already taken, and its result holds until the receiver takes the first
module occupancy_grid_rect_engine #(
	parameter int MAX_COLS  = ogre_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS  = ogre_pkg::MAX_ROWS_DEF,
	parameter int COST_BITS = ogre_pkg::COST_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	ogre_in_if.sink                        in_ch,
	ogre_out_if.source                     out_ch,
	input  logic                           cfg_we,
	input  logic [ogre_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ogre_pkg::CFG_W-1:0]     cfg_data
);

	// command and status between sequencer and datapath
	ogre_pkg::cmd_t    cmd;
	ogre_pkg::status_t status;

	ogre_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// grid registers, scan counters, memories and result register
	ogre_dp #(
		.MAX_COLS  (MAX_COLS),
		.MAX_ROWS  (MAX_ROWS),
		.COST_BITS (COST_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.operation   (in_ch.operation),
		.left_col    (in_ch.left_col),
		.top_row     (in_ch.top_row),
		.right_col   (in_ch.right_col),
		.bottom_row  (in_ch.bottom_row),
		.block_value (in_ch.block_value),
		.cost_delta  (in_ch.cost_delta),
		.cmd         (cmd),
		.status      (status),
		.blocked     (out_ch.blocked),
		.cost_sum    (out_ch.cost_sum)
	);

endmodule
